FILE: sv/shift_subtract_divider_64_assert.svh
// ----------------------------------------------------------------------------
// Shift-subtract divider assertion macros
// Shared macros for the concurrent checks on the divider ports.
// ----------------------------------------------------------------------------
`ifndef SHIFT_SUBTRACT_DIVIDER_64_ASSERT_SVH
`define SHIFT_SUBTRACT_DIVIDER_64_ASSERT_SVH

// Check that is switched off while the reset is held.
`define SSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that also runs during reset.
`define SSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);

`endif

FILE: sv/ssd64_pkg.sv
// ----------------------------------------------------------------------------
// Shift-subtract divider package
// Widths, controller states and the command and status types of the divider.
// ----------------------------------------------------------------------------
package ssd64_pkg;

    localparam int DATA_WIDTH  = 64;
    localparam int FIELD_W     = 64;
    localparam int CNT_W       = $clog2(DATA_WIDTH);
    localparam int TDATA_IN_W  = ((2 * FIELD_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((2 * FIELD_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_FIX
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic fix;
    } t_dp_cmd;

    typedef struct packed {
        logic last_step;
    } t_dp_sts;

endpackage

FILE: sv/ssd64_ctrl.sv
// ----------------------------------------------------------------------------
// Shift-subtract divider controller
// Sequences operand load, the bit steps and the sign fix, and owns the
// valid flag of the output register.
// ----------------------------------------------------------------------------
module ssd64_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  ssd64_pkg::t_dp_sts i_sts,
    output ssd64_pkg::t_dp_cmd o_cmd
);
    import ssd64_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (i_sts.last_step) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                o_cmd.load    = s_axis_tvalid;
            end
            ST_CALC: begin
                o_cmd.step = 1'b1;
            end
            ST_FIX: begin
                o_cmd.fix = out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.fix) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: sv/ssd64_dpath.sv
// ----------------------------------------------------------------------------
// Shift-subtract divider datapath
// Operand magnitudes, the restoring divide step, the bit counter, the sign
// fix and the output register.
// ----------------------------------------------------------------------------
module ssd64_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ssd64_pkg::t_dp_cmd                i_cmd,
    output ssd64_pkg::t_dp_sts                o_sts,
    input  logic [ssd64_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    input  logic                              s_axis_tuser,
    output logic [ssd64_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    output logic                              m_axis_tuser
);
    import ssd64_pkg::*;

    logic [DATA_WIDTH-1:0] in_dividend;
    logic [DATA_WIDTH-1:0] in_divisor;
    logic                  in_n_neg;
    logic                  in_d_neg;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH+1:0] diff;
    logic                  fits;

    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_div;
    logic                  r_n_neg;
    logic                  r_q_neg;
    logic                  r_dbz;
    logic [CNT_W-1:0]      r_cnt;
    logic [DATA_WIDTH-1:0] r_out_quo;
    logic [DATA_WIDTH-1:0] r_out_rem;
    logic                  r_out_dbz;

    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_quo;
    logic [CNT_W-1:0]      n_cnt;
    logic [DATA_WIDTH-1:0] n_out_quo;
    logic [DATA_WIDTH-1:0] n_out_rem;

    assign in_dividend = s_axis_tdata[DATA_WIDTH-1:0];
    assign in_divisor  = s_axis_tdata[FIELD_W +: DATA_WIDTH];
    assign in_n_neg    = s_axis_tuser && in_dividend[DATA_WIDTH-1];
    assign in_d_neg    = s_axis_tuser && in_divisor[DATA_WIDTH-1];

    assign shifted = {r_rem, r_quo[DATA_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_div};
    assign fits    = !diff[DATA_WIDTH+1];

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        n_cnt = r_cnt;
        if (i_cmd.load) begin
            n_rem = '0;
            n_quo = in_n_neg ? (~in_dividend + 1'b1) : in_dividend;
            n_cnt = CNT_W'(DATA_WIDTH - 1);
        end else if (i_cmd.step) begin
            n_rem = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
            n_quo = {r_quo[DATA_WIDTH-2:0], fits};
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_comb begin
        n_out_quo = r_q_neg ? (~r_quo + 1'b1) : r_quo;
        n_out_rem = r_n_neg ? (~r_rem + 1'b1) : r_rem;
        if (r_dbz) begin
            n_out_quo = '0;
            n_out_rem = '0;
        end
    end

    assign o_sts.last_step = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_cmd.load) begin
            r_div   <= in_d_neg ? (~in_divisor + 1'b1) : in_divisor;
            r_n_neg <= in_n_neg;
            r_q_neg <= in_n_neg ^ in_d_neg;
            r_dbz   <= (in_divisor == '0);
        end
        if (i_cmd.fix) begin
            r_out_quo <= n_out_quo;
            r_out_rem <= n_out_rem;
            r_out_dbz <= r_dbz;
        end
    end

    assign m_axis_tdata = TDATA_OUT_W'({FIELD_W'(r_out_rem), FIELD_W'(r_out_quo)});
    assign m_axis_tuser = r_out_dbz;

endmodule

FILE: sv/shift_subtract_divider_64.sv
// Operation: the input transfer loads the operand magnitudes, then come 64 restoring
// steps (one quotient bit each through a single shared subtractor) and a sign fix
// step, which waits while the output register holds a result not yet taken.
// Operands are taken only in the idle state, after the sign fix; a finished result
// may wait in the output register while the next operands are accepted.
// Reset: synchronous, active low; clears the controller and the output valid.
// ----------------------------------------------------------------------------
// Shift-subtract divider, top level
// Signed and unsigned restoring divider returning quotient, remainder and a
// divide-by-zero flag.
// ----------------------------------------------------------------------------
module shift_subtract_divider_64 (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0: dividend[63:0], divisor[127:64].
    input  logic [ssd64_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    // Fields from bit 0: func (0 unsigned, 1 signed).
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0: quotient[63:0], remainder[127:64].
    output logic [ssd64_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    // Fields from bit 0: divide_by_zero.
    output logic                              m_axis_tuser
);
    import ssd64_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    ssd64_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (dp_sts),
        .o_cmd         (dp_cmd)
    );

    ssd64_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

endmodule

FILE: sv/ssd64_checker.sv
// ----------------------------------------------------------------------------
// Shift-subtract divider checker
// Port-level checks on the divider, attached to the top level by a bind.
// ----------------------------------------------------------------------------
`include "shift_subtract_divider_64_assert.svh"

module ssd64_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [ssd64_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    input logic                              s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [ssd64_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    input logic                              m_axis_tuser
);
    import ssd64_pkg::*;

    logic in_xfer;
    logic out_stall;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    `SSD_ASSERT(a_out_valid_holds, out_stall |=> m_axis_tvalid, "Result withdrawn while stalled.")
    `SSD_ASSERT(a_out_data_holds, out_stall |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "Result changed while stalled.")
    `SSD_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !m_axis_tvalid, "Result valid after reset.")
    `SSD_ASSERT(a_dbz_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "Divide by zero with nonzero result.")
    `SSD_ASSERT(a_busy_after_xfer, in_xfer |=> !s_axis_tready, "Operands accepted while a division is running.")

endmodule

bind shift_subtract_divider_64 ssd64_checker u_checker (.*);
